>>> rtl/clipped_bitmap_text_renderer_assert.svh
// Assertion helpers shared by the renderer modules.
// Both expect clk and rst in scope; checks are off while rst is high.
`ifndef CLIPPED_BITMAP_TEXT_RENDERER_ASSERT_SVH
`define CLIPPED_BITMAP_TEXT_RENDERER_ASSERT_SVH

// Same-cycle implication
`define CBTR_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define CBTR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/cbtr_pkg.sv
package cbtr_pkg;

  // Field widths of the channels
  localparam int CHAR_W   = 8;
  localparam int START_W  = 13;
  localparam int ADDR_W   = 13;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 14;
  localparam int MASK_W   = 16;
  localparam int KIND_W   = 2;

  // Configuration register widths
  localparam int CLIP_W      = 12;
  localparam int SIZE_W      = 5;
  localparam int STRIDE_W    = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Font bit addressing: bits per byte and the bit-in-byte select
  localparam int BYTE_BITS = 8;
  localparam int BIT_SEL_W = 3;
  localparam int PROD_W    = CHAR_W + STRIDE_W;

  // Character codes with special meaning
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_DOT     = 8'hF4;

  // Request types
  localparam logic REQ_DRAW  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_GLYPH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNDER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOT   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_W     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_H     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE      = 3'd6;

  // Configuration reset values
  localparam logic [CLIP_W-1:0]   CLIP_LEFT_RST   = 12'd0;
  localparam logic [CLIP_W-1:0]   CLIP_TOP_RST    = 12'd0;
  localparam logic [CLIP_W-1:0]   CLIP_RIGHT_RST  = 12'd4095;
  localparam logic [CLIP_W-1:0]   CLIP_BOTTOM_RST = 12'd4095;
  localparam logic [SIZE_W-1:0]   GLYPH_W_RST     = 5'd8;
  localparam logic [SIZE_W-1:0]   GLYPH_H_RST     = 5'd8;
  localparam logic [STRIDE_W-1:0] STRIDE_RST      = 9'd64;

  // Sequencer to row packer
  typedef struct packed {
    logic start;  // clear the accumulator, next byte is the first
    logic take;   // pop one glyph row
    logic fill;   // font byte on the read data this cycle
  } pk_ctrl_t;

  // Row packer to sequencer
  typedef struct packed {
    logic row_ready;  // at least one full row buffered
    logic want_byte;  // room for another byte after this cycle
  } pk_stat_t;

endpackage

>>> rtl/cbtr_req_if.sv
interface cbtr_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [cbtr_pkg::CHAR_W-1:0]       char_code;
  logic                              first_of_string;
  logic signed [cbtr_pkg::START_W-1:0] start_x;
  logic signed [cbtr_pkg::START_W-1:0] start_y;
  logic                              underlined;
  logic [cbtr_pkg::ADDR_W-1:0]       font_addr;
  logic [cbtr_pkg::BYTE_W-1:0]       font_byte;

  modport source (
    output valid, req_type, char_code, first_of_string, start_x, start_y,
           underlined, font_addr, font_byte,
    input  ready
  );

  modport sink (
    input  valid, req_type, char_code, first_of_string, start_x, start_y,
           underlined, font_addr, font_byte,
    output ready
  );
endinterface

>>> rtl/cbtr_run_if.sv
interface cbtr_run_if;
  logic                              valid;
  logic                              ready;
  logic signed [cbtr_pkg::ROW_W-1:0] row_y;
  logic signed [cbtr_pkg::ROW_W-1:0] row_x;
  logic [cbtr_pkg::MASK_W-1:0]       pixel_mask;
  logic [cbtr_pkg::KIND_W-1:0]       run_kind;
  logic                              last_of_item;

  modport source (
    output valid, row_y, row_x, pixel_mask, run_kind, last_of_item,
    input  ready
  );

  modport sink (
    input  valid, row_y, row_x, pixel_mask, run_kind, last_of_item,
    output ready
  );
endinterface

>>> rtl/cbtr_font_mem.sv
module cbtr_font_mem #(
  parameter int FONT_BYTES = 8192,
  localparam int AW = $clog2(FONT_BYTES)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [cbtr_pkg::BYTE_W-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [cbtr_pkg::BYTE_W-1:0]   rdata
);

  logic [cbtr_pkg::BYTE_W-1:0] mem [FONT_BYTES];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cbtr_row_packer.sv
`include "clipped_bitmap_text_renderer_assert.svh"

module cbtr_row_packer #(
  parameter int MAX_GLYPH_WIDTH = 16,
  localparam int WW = $clog2(MAX_GLYPH_WIDTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cbtr_pkg::pk_ctrl_t            ctrl,
  input  logic [cbtr_pkg::BIT_SEL_W-1:0] off,
  input  logic [WW-1:0]                 w,
  input  logic [cbtr_pkg::BYTE_W-1:0]   data,
  output logic [MAX_GLYPH_WIDTH-1:0]    row,
  output cbtr_pkg::pk_stat_t            stat
);

  localparam int ACC_W = MAX_GLYPH_WIDTH + 2 * cbtr_pkg::BYTE_BITS;
  localparam int CW    = $clog2(ACC_W + 1);
  localparam int CW1   = CW + 1;

  logic [ACC_W-1:0]            acc;
  logic [ACC_W-1:0]            acc_take;
  logic [ACC_W-1:0]            acc_next;
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               cnt_take;
  logic [CW-1:0]               cnt_next;
  logic [CW-1:0]               nbits;
  logic [CW1-1:0]              room_need;
  logic [cbtr_pkg::BYTE_W-1:0] data_sh;
  logic                        first;

  // Pop a row, then append the arriving byte above what is left
  always_comb begin
    cnt_take  = ctrl.take ? cnt - CW'(w) : cnt;
    acc_take  = ctrl.take ? acc >> w : acc;
    data_sh   = first ? data >> off : data;
    nbits     = first ? CW'(cbtr_pkg::BYTE_BITS - int'(off)) : CW'(cbtr_pkg::BYTE_BITS);
    acc_next  = ctrl.fill ? (acc_take | (ACC_W'(data_sh) << cnt_take)) : acc_take;
    cnt_next  = ctrl.fill ? cnt_take + nbits : cnt_take;
    room_need = CW1'(cnt_next) + CW1'(cbtr_pkg::BYTE_BITS);
  end

  assign stat.want_byte = room_need <= CW1'(ACC_W);
  assign stat.row_ready = cnt >= CW'(w);
  assign row            = acc[MAX_GLYPH_WIDTH-1:0];

  // Bit count and first-byte flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      first <= 1'b1;
    end else if (ctrl.start) begin
      cnt   <= '0;
      first <= 1'b1;
    end else begin
      cnt <= cnt_next;
      if (ctrl.fill) begin
        first <= 1'b0;
      end
    end
  end

  // Bit accumulator
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  `CBTR_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt <= CW'(ACC_W), "row packer holds more bits than it has room for")
  `CBTR_ASSERT_IMPL(a_fill_requested, ctrl.fill, $past(stat.want_byte), "font byte arrived without room requested")

endmodule

>>> rtl/clipped_bitmap_text_renderer.sv
// Clipped bitmap text renderer. Each draw item is one character of a string; the block keeps the
// text cursor and line start, fetches the glyph from the internal font store one byte per cycle
// while the row packer has room, and emits one 16-bit pixel mask per glyph row, clipped to the clip
// rectangle, then an optional underline run. Code 0xF4 gives one centre-dot result when the dot
// lies inside the clip rectangle; newline and rejected glyphs give none. Write items load font
// bytes; a font byte must be written before any glyph reads it, and the store has no clearing pass
// after reset. One item is in work at a time and the input is not ready meanwhile. A font address,
// for writes and glyph reads alike, is reduced modulo the store size by subtracting FONT_BYTES.
// A drawn glyph is fetched through the single font read port, and result stalls hold its rows.
`include "clipped_bitmap_text_renderer_assert.svh"

module clipped_bitmap_text_renderer #(
  parameter int MAX_GLYPH_WIDTH  = 16,
  parameter int MAX_GLYPH_HEIGHT = 16,
  parameter int FONT_BYTES       = 8192,
  parameter int COORD_BITS       = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  cbtr_req_if.sink                            req,
  cbtr_run_if.source                          run,
  input  logic                                cfg_we,
  input  logic [cbtr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cbtr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WW  = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int HW  = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int EW  = ((COORD_BITS > cbtr_pkg::START_W) ? COORD_BITS : cbtr_pkg::START_W) + 2;
  localparam int AW  = $clog2(FONT_BYTES);
  localparam int RW  = ((AW + 1) > (cbtr_pkg::PROD_W - cbtr_pkg::BIT_SEL_W)) ?
                       (AW + 1) : (cbtr_pkg::PROD_W - cbtr_pkg::BIT_SEL_W);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_REDUCE = 6'b000100,
    S_STREAM = 6'b001000,
    S_UNDER  = 6'b010000,
    S_DOT    = 6'b100000
  } state_t;

  state_t state;

  // Configuration
  logic [cbtr_pkg::CLIP_W-1:0]   clip_left;
  logic [cbtr_pkg::CLIP_W-1:0]   clip_top;
  logic [cbtr_pkg::CLIP_W-1:0]   clip_right;
  logic [cbtr_pkg::CLIP_W-1:0]   clip_bottom;
  logic [cbtr_pkg::SIZE_W-1:0]   glyph_width;
  logic [cbtr_pkg::SIZE_W-1:0]   glyph_height;
  logic [cbtr_pkg::STRIDE_W-1:0] glyph_stride_bits;

  // Text position
  logic signed [COORD_BITS-1:0]  cursor_x;
  logic signed [COORD_BITS-1:0]  cursor_y;
  logic signed [COORD_BITS-1:0]  line_x;

  // Item in work
  logic [cbtr_pkg::CHAR_W-1:0]   code_r;
  logic                          under_r;
  logic                          is_wr;
  logic [cbtr_pkg::BYTE_W-1:0]   byte_r;
  logic [cbtr_pkg::PROD_W-1:0]   prod_r;
  logic [RW-1:0]                 work;
  logic [cbtr_pkg::BIT_SEL_W-1:0] off_r;
  logic signed [COORD_BITS-1:0]  x_r;
  logic signed [COORD_BITS-1:0]  y_r;
  logic signed [EW-1:0]          lo_r;
  logic signed [EW-1:0]          hi_r;
  logic [MAX_GLYPH_WIDTH-1:0]    colmask;
  logic [MAX_GLYPH_WIDTH-1:0]    colmask_calc;
  logic [HW-1:0]                 row_idx;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_pend;

  // Output register
  logic                          run_valid_r;
  logic signed [cbtr_pkg::ROW_W-1:0] out_y;
  logic signed [cbtr_pkg::ROW_W-1:0] out_x;
  logic [cbtr_pkg::MASK_W-1:0]   out_mask;
  logic [cbtr_pkg::KIND_W-1:0]   out_kind;
  logic                          out_last;

  // Arithmetic
  logic [WW-1:0]                 w_sat;
  logic [HW-1:0]                 h_sat;
  logic signed [EW-1:0]          xe, ye, we, he, wh, hh;
  logic signed [EW-1:0]          xre, yre;
  logic signed [EW-1:0]          cle, cte, cre, cbe;
  logic signed [EW-1:0]          xsum, ysum;
  logic signed [EW-1:0]          sxe, sye;
  logic signed [EW-1:0]          pxe, pye, pxre, pyre;
  logic signed [EW-1:0]          rye, uye;
  logic                          dot_in, reject, row_in, under_in;
  logic                          reduce_more;

  // Handshake and sequencing
  logic                          slot_free;
  logic                          take;
  logic                          last_row;
  logic                          issue;
  logic                          out_load;
  logic                          out_last_sel;
  logic [31:0]                   row_wide;

  // Packer and memory hookup
  cbtr_pkg::pk_ctrl_t            pk_ctrl;
  cbtr_pkg::pk_stat_t            pk_stat;
  logic [MAX_GLYPH_WIDTH-1:0]    pk_row;
  logic [cbtr_pkg::BYTE_W-1:0]   mem_q;
  logic                          mem_we;

  // Saturate the glyph size
  always_comb begin
    if (glyph_width == '0) begin
      w_sat = WW'(1);
    end else if (int'(glyph_width) > MAX_GLYPH_WIDTH) begin
      w_sat = WW'(MAX_GLYPH_WIDTH);
    end else begin
      w_sat = WW'(glyph_width);
    end
    if (glyph_height == '0) begin
      h_sat = HW'(1);
    end else if (int'(glyph_height) > MAX_GLYPH_HEIGHT) begin
      h_sat = HW'(MAX_GLYPH_HEIGHT);
    end else begin
      h_sat = HW'(glyph_height);
    end
  end

  // Extend to the working coordinate width
  assign xe  = EW'(cursor_x);
  assign ye  = EW'(cursor_y);
  assign xre = EW'(x_r);
  assign yre = EW'(y_r);
  assign we  = EW'(w_sat);
  assign he  = EW'(h_sat);
  assign wh  = EW'(w_sat >> 1);
  assign hh  = EW'(h_sat >> 1);
  assign cle = EW'(clip_left);
  assign cte = EW'(clip_top);
  assign cre = EW'(clip_right);
  assign cbe = EW'(clip_bottom);
  assign sxe = EW'(req.start_x);
  assign sye = EW'(req.start_y);

  assign xsum = xe + we;
  assign ysum = ye + he;
  assign pxe  = xe + wh;
  assign pye  = ye + hh;
  assign pxre = xre + wh;
  assign pyre = yre + hh;
  assign rye  = yre + EW'(row_idx);
  assign uye  = yre + he;

  assign dot_in   = (pye >= cte) && (pye < cbe) && (pxe >= cle) && (pxe < cre);
  assign reject   = (xsum < cle) || (xe > cre) || (ysum < cte) || (ye > cbe);
  assign row_in   = (rye >= cte) && (rye < cbe);
  assign under_in = (uye >= cte) && (uye < cbe);

  assign reduce_more = work >= RW'(FONT_BYTES);

  // Column window, shared by glyph rows and the underline
  always_comb begin
    for (int j = 0; j < MAX_GLYPH_WIDTH; j++) begin
      colmask_calc[j] = (j < int'(w_sat)) && (EW'(j) >= lo_r) && (EW'(j) < hi_r);
    end
  end

  assign slot_free = !run_valid_r || run.ready;
  assign take      = (state == S_STREAM) && pk_stat.row_ready && slot_free;
  assign last_row  = HW'(row_idx + 1'b1) == h_sat;
  assign issue     = (state == S_STREAM) && pk_stat.want_byte;
  assign out_load  = take || (((state == S_UNDER) || (state == S_DOT)) && slot_free);
  assign out_last_sel = take ? (last_row && !under_r) : 1'b1;
  assign row_wide  = 32'(pk_row & colmask);

  assign mem_we        = (state == S_REDUCE) && !reduce_more && is_wr;
  assign pk_ctrl.start = (state == S_REDUCE) && !reduce_more && !is_wr;
  assign pk_ctrl.take  = take;
  assign pk_ctrl.fill  = rd_pend;

  assign req.ready        = (state == S_IDLE);
  assign run.valid        = run_valid_r;
  assign run.row_y        = out_y;
  assign run.row_x        = out_x;
  assign run.pixel_mask   = out_mask;
  assign run.run_kind     = out_kind;
  assign run.last_of_item = out_last;

  cbtr_font_mem #(
    .FONT_BYTES (FONT_BYTES)
  ) u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (work[AW-1:0]),
    .wdata (byte_r),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  cbtr_row_packer #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_row_packer (
    .clk  (clk),
    .rst  (rst),
    .ctrl (pk_ctrl),
    .off  (off_r),
    .w    (w_sat),
    .data (mem_q),
    .row  (pk_row),
    .stat (pk_stat)
  );

  // Sequencer, configuration and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      run_valid_r       <= 1'b0;
      rd_pend           <= 1'b0;
      row_idx           <= '0;
      cursor_x          <= '0;
      cursor_y          <= '0;
      line_x            <= '0;
      clip_left         <= cbtr_pkg::CLIP_LEFT_RST;
      clip_top          <= cbtr_pkg::CLIP_TOP_RST;
      clip_right        <= cbtr_pkg::CLIP_RIGHT_RST;
      clip_bottom       <= cbtr_pkg::CLIP_BOTTOM_RST;
      glyph_width       <= cbtr_pkg::GLYPH_W_RST;
      glyph_height      <= cbtr_pkg::GLYPH_H_RST;
      glyph_stride_bits <= cbtr_pkg::STRIDE_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cbtr_pkg::CFG_CLIP_LEFT:   clip_left         <= cfg_data[cbtr_pkg::CLIP_W-1:0];
          cbtr_pkg::CFG_CLIP_TOP:    clip_top          <= cfg_data[cbtr_pkg::CLIP_W-1:0];
          cbtr_pkg::CFG_CLIP_RIGHT:  clip_right        <= cfg_data[cbtr_pkg::CLIP_W-1:0];
          cbtr_pkg::CFG_CLIP_BOTTOM: clip_bottom       <= cfg_data[cbtr_pkg::CLIP_W-1:0];
          cbtr_pkg::CFG_GLYPH_W:     glyph_width       <= cfg_data[cbtr_pkg::SIZE_W-1:0];
          cbtr_pkg::CFG_GLYPH_H:     glyph_height      <= cfg_data[cbtr_pkg::SIZE_W-1:0];
          cbtr_pkg::CFG_STRIDE:      glyph_stride_bits <= cfg_data[cbtr_pkg::STRIDE_W-1:0];
          default: ;
        endcase
      end

      // Hold the result until its transfer
      if (out_load) begin
        run_valid_r <= 1'b1;
      end else if (run.ready) begin
        run_valid_r <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.req_type == cbtr_pkg::REQ_WRITE) begin
              state <= S_REDUCE;
            end else begin
              if (req.first_of_string) begin
                cursor_x <= sxe[COORD_BITS-1:0];
                cursor_y <= sye[COORD_BITS-1:0];
                line_x   <= sxe[COORD_BITS-1:0];
              end
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          if (code_r == cbtr_pkg::CODE_NEWLINE) begin
            cursor_y <= ysum[COORD_BITS-1:0];
            cursor_x <= line_x;
            state    <= S_IDLE;
          end else begin
            cursor_x <= xsum[COORD_BITS-1:0];
            if (code_r == cbtr_pkg::CODE_DOT) begin
              state <= dot_in ? S_DOT : S_IDLE;
            end else begin
              state <= reject ? S_IDLE : S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (!reduce_more) begin
            if (is_wr) begin
              state <= S_IDLE;
            end else begin
              row_idx <= '0;
              state   <= S_STREAM;
            end
          end
        end
        S_STREAM: begin
          rd_pend <= issue && !(take && last_row);
          if (take) begin
            row_idx <= HW'(row_idx + 1'b1);
            if (last_row) begin
              state <= under_r ? S_UNDER : S_IDLE;
            end
          end
        end
        S_UNDER, S_DOT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item latches, address reduction and glyph window
  always_ff @(posedge clk) begin
    priority if (state == S_IDLE && req.valid) begin
      code_r  <= req.char_code;
      under_r <= req.underlined;
      is_wr   <= (req.req_type == cbtr_pkg::REQ_WRITE);
      byte_r  <= req.font_byte;
      prod_r  <= cbtr_pkg::PROD_W'(req.char_code) * cbtr_pkg::PROD_W'(glyph_stride_bits);
      work    <= RW'(req.font_addr);
    end else if (state == S_SETUP) begin
      x_r   <= cursor_x;
      y_r   <= cursor_y;
      lo_r  <= cle - xe;
      hi_r  <= cre - xe;
      work  <= RW'(prod_r >> cbtr_pkg::BIT_SEL_W);
      off_r <= prod_r[cbtr_pkg::BIT_SEL_W-1:0];
    end else if (state == S_REDUCE) begin
      colmask <= colmask_calc;
      if (reduce_more) begin
        work <= work - RW'(FONT_BYTES);
      end else begin
        rd_addr <= work[AW-1:0];
      end
    end else if (state == S_STREAM && issue) begin
      rd_addr <= (rd_addr == AW'(FONT_BYTES - 1)) ? '0 : AW'(rd_addr + 1'b1);
    end else begin
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_last <= out_last_sel;
      priority if (take) begin
        out_y    <= rye[cbtr_pkg::ROW_W-1:0];
        out_x    <= xre[cbtr_pkg::ROW_W-1:0];
        out_mask <= row_in ? row_wide[cbtr_pkg::MASK_W-1:0] : '0;
        out_kind <= cbtr_pkg::KIND_GLYPH;
      end else if (state == S_UNDER) begin
        out_y    <= uye[cbtr_pkg::ROW_W-1:0];
        out_x    <= xre[cbtr_pkg::ROW_W-1:0];
        out_mask <= under_in ? cbtr_pkg::MASK_W'(32'(colmask)) : '0;
        out_kind <= cbtr_pkg::KIND_UNDER;
      end else begin
        out_y    <= pyre[cbtr_pkg::ROW_W-1:0];
        out_x    <= pxre[cbtr_pkg::ROW_W-1:0];
        out_mask <= cbtr_pkg::MASK_W'(1);
        out_kind <= cbtr_pkg::KIND_DOT;
      end
    end
  end

  `CBTR_ASSERT_IMPL(a_row_bound, state == S_STREAM, row_idx < h_sat, "glyph row index past glyph height")
  `CBTR_ASSERT_NEXT(a_last_ends_item, out_load && out_last_sel, state == S_IDLE, "last result loaded but item still in work")
  `CBTR_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, state != S_IDLE, "input transfer did not start work")

endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbtr_pkg::*;

  localparam int FONT_BYTES       = 8192;
  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int MAX_GLYPH_HEIGHT = 16;
  localparam int MAX_REPORTS      = 10;
  localparam int DRAIN_CYCLES     = 64;
  localparam int WATCHDOG_LIMIT   = 2000;

  typedef enum {PACE_SRC_LIGHT, PACE_SRC_HEAVY, PACE_NONE} pacing_t;

  // One request on the input channel
  typedef struct packed {
    logic                      req_type;
    logic [CHAR_W-1:0]         char_code;
    logic                      first_of_string;
    logic signed [START_W-1:0] start_x;
    logic signed [START_W-1:0] start_y;
    logic                      underlined;
    logic [ADDR_W-1:0]         font_addr;
    logic [BYTE_W-1:0]         font_byte;
  } glyph_req_t;

  // One pixel run on the output channel
  typedef struct packed {
    logic [ROW_W-1:0]  row_y;
    logic [ROW_W-1:0]  row_x;
    logic [MASK_W-1:0] pixel_mask;
    logic [KIND_W-1:0] run_kind;
    logic              last_of_item;
  } pixel_run_t;

  // Text raster model: cursor, font copy and clip setup; holds the runs still owed
  class glyph_run_model;
    logic [7:0]  font_mem [FONT_BYTES];
    int          cur_x, cur_y, line_x;
    int unsigned clip_l, clip_t, clip_r, clip_b;
    int unsigned cell_w, cell_h, stride;
    pixel_run_t  pending_runs[$];
    int          mismatches;
    int          runs_checked;

    function new();
      foreach (font_mem[i]) font_mem[i] = 8'h00;
      cur_x = 0;
      cur_y = 0;
      line_x = 0;
      clip_l = CLIP_LEFT_RST;
      clip_t = CLIP_TOP_RST;
      clip_r = CLIP_RIGHT_RST;
      clip_b = CLIP_BOTTOM_RST;
      cell_w = GLYPH_W_RST;
      cell_h = GLYPH_H_RST;
      stride = STRIDE_RST;
      mismatches = 0;
      runs_checked = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CLIP_LEFT:   clip_l = val[CLIP_W-1:0];
        CFG_CLIP_TOP:    clip_t = val[CLIP_W-1:0];
        CFG_CLIP_RIGHT:  clip_r = val[CLIP_W-1:0];
        CFG_CLIP_BOTTOM: clip_b = val[CLIP_W-1:0];
        CFG_GLYPH_W:     cell_w = val[SIZE_W-1:0];
        CFG_GLYPH_H:     cell_h = val[SIZE_W-1:0];
        CFG_STRIDE:      stride = val[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function int cell_size(int unsigned v, int unsigned top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
    endfunction

    // Byte range (unreduced) that a glyph of this code covers in the font
    function void glyph_span(logic [CHAR_W-1:0] code, output int unsigned lo,
                             output int unsigned hi);
      int unsigned base;
      int unsigned nbits;
      base = code * stride;
      nbits = cell_size(cell_w, MAX_GLYPH_WIDTH) * cell_size(cell_h, MAX_GLYPH_HEIGHT);
      lo = base >> 3;
      hi = (base + nbits - 1) >> 3;
    endfunction

    function int wrap_coord(int v);
      logic signed [ROW_W-1:0] t;
      t = v[ROW_W-1:0];
      return int'(t);
    endfunction

    function bit font_bit(int unsigned b);
      return font_mem[(b >> 3) % FONT_BYTES][b % 8];
    endfunction

    function pixel_run_t make_run(int ry, int rx, logic [MASK_W-1:0] m,
                                  logic [KIND_W-1:0] kind);
      pixel_run_t run;
      run.row_y = ry[ROW_W-1:0];
      run.row_x = rx[ROW_W-1:0];
      run.pixel_mask = m;
      run.run_kind = kind;
      run.last_of_item = 1'b0;
      return run;
    endfunction

    // Advance the raster state by one accepted request and queue its runs
    function void note_request(glyph_req_t r);
      int x, y, cl, ct, cr, cb, wi, hi, ry, cx, uy, lx, rx, px, py, i, j, k;
      int unsigned base;
      logic [MASK_W-1:0] mask;
      pixel_run_t batch[$];
      pixel_run_t run;
      if (r.req_type == REQ_WRITE) begin
        font_mem[r.font_addr % FONT_BYTES] = r.font_byte;
        return;
      end
      if (r.first_of_string) begin
        cur_x = wrap_coord(int'($signed(r.start_x)));
        cur_y = wrap_coord(int'($signed(r.start_y)));
        line_x = cur_x;
      end
      wi = cell_size(cell_w, MAX_GLYPH_WIDTH);
      hi = cell_size(cell_h, MAX_GLYPH_HEIGHT);
      x = cur_x;
      y = cur_y;
      cl = clip_l;
      ct = clip_t;
      cr = clip_r;
      cb = clip_b;

      // Newline: back to the line start, one cell down
      if (r.char_code == CODE_NEWLINE) begin
        cur_y = wrap_coord(y + hi);
        cur_x = line_x;
        return;
      end

      if (r.char_code == CODE_DOT) begin
        px = x + wi / 2;
        py = y + hi / 2;
        if (py >= ct && py < cb && px >= cl && px < cr)
          batch.push_back(make_run(py, px, 1, KIND_DOT));
      end else if (!(x + wi < cl || x > cr || y + hi < ct || y > cb)) begin
        base = r.char_code * stride;
        for (i = 0; i < hi; i++) begin
          ry = y + i;
          mask = '0;
          if (ry >= ct && ry < cb) begin
            for (j = 0; j < wi; j++) begin
              cx = x + j;
              if (cx >= cl && cx < cr && font_bit(base + i * wi + j))
                mask[j] = 1'b1;
            end
          end
          batch.push_back(make_run(ry, x, mask, KIND_GLYPH));
        end
        // Underline span one row below the cell, clipped in both directions
        if (r.underlined) begin
          uy = y + hi;
          lx = (x < cl) ? cl : x;
          rx = (x + wi > cr) ? cr : x + wi;
          mask = '0;
          if (uy >= ct && uy < cb) begin
            for (j = 0; j < wi; j++) begin
              cx = x + j;
              if (cx >= lx && cx < rx)
                mask[j] = 1'b1;
            end
          end
          batch.push_back(make_run(uy, x, mask, KIND_UNDER));
        end
      end

      cur_x = wrap_coord(x + wi);
      for (k = 0; k < batch.size(); k++) begin
        run = batch[k];
        run.last_of_item = (k == batch.size() - 1);
        pending_runs.push_back(run);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Compare one output transfer with the oldest owed run
    function void check_run(pixel_run_t got);
      pixel_run_t want;
      if (pending_runs.size() == 0) begin
        flag($sformatf("run with none owed: y=%0d x=%0d mask=%h kind=%0d last=%0d",
                       $signed(got.row_y), $signed(got.row_x), got.pixel_mask,
                       got.run_kind, got.last_of_item));
        return;
      end
      want = pending_runs.pop_front();
      runs_checked++;
      if (got.row_y !== want.row_y || got.row_x !== want.row_x ||
          got.pixel_mask !== want.pixel_mask || got.run_kind !== want.run_kind ||
          got.last_of_item !== want.last_of_item)
        flag($sformatf({"expected y=%0d x=%0d mask=%h kind=%0d last=%0d, ",
                        "got y=%0d x=%0d mask=%h kind=%0d last=%0d"},
                       $signed(want.row_y), $signed(want.row_x), want.pixel_mask,
                       want.run_kind, want.last_of_item,
                       $signed(got.row_y), $signed(got.row_x), got.pixel_mask,
                       got.run_kind, got.last_of_item));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cbtr_req_if req_bus ();
  cbtr_run_if run_bus ();

  clipped_bitmap_text_renderer dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .run       (run_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_run_model raster = new();
  bit             font_written [FONT_BYTES];
  int             src_idle_pct;
  int             sink_idle_pct;
  int             requests_sent;
  int             font_writes_sent;
  int             settings_run;
  int             quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver stalls
  always @(negedge clk) begin
    run_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Check every output transfer
  always @(posedge clk) begin
    pixel_run_t seen;
    if (!rst && run_bus.valid && run_bus.ready) begin
      seen.row_y = run_bus.row_y;
      seen.row_x = run_bus.row_x;
      seen.pixel_mask = run_bus.pixel_mask;
      seen.run_kind = run_bus.run_kind;
      seen.last_of_item = run_bus.last_of_item;
      raster.check_run(seen);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (run_bus.valid && run_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d runs still owed",
               quiet_cycles, raster.pending_runs.size());
      $display("[clipped_bitmap_text_renderer] ERROR");
      $finish;
    end
  end

  task automatic set_pacing(pacing_t p);
    case (p)
      PACE_SRC_LIGHT: begin
        src_idle_pct = 36;
        sink_idle_pct = 69;
      end
      PACE_SRC_HEAVY: begin
        src_idle_pct = 69;
        sink_idle_pct = 36;
      end
      default: begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
    endcase
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    raster.write_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  task automatic set_clip(int unsigned l, int unsigned t, int unsigned r, int unsigned b);
    cfg_write(CFG_CLIP_LEFT, l);
    cfg_write(CFG_CLIP_TOP, t);
    cfg_write(CFG_CLIP_RIGHT, r);
    cfg_write(CFG_CLIP_BOTTOM, b);
  endtask

  task automatic set_glyph(int unsigned w, int unsigned h, int unsigned s);
    cfg_write(CFG_GLYPH_W, w);
    cfg_write(CFG_GLYPH_H, h);
    cfg_write(CFG_STRIDE, s);
  endtask

  task automatic random_clip();
    int unsigned l, t;
    l = $urandom_range(0, 400);
    t = $urandom_range(0, 400);
    set_clip(l, t, l + $urandom_range(8, 300), t + $urandom_range(8, 300));
  endtask

  // Present one request, wait for its transfer, then hand it to the model
  task automatic send_request(glyph_req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk);
    req_bus.valid <= 1'b1;
    req_bus.req_type <= r.req_type;
    req_bus.char_code <= r.char_code;
    req_bus.first_of_string <= r.first_of_string;
    req_bus.start_x <= r.start_x;
    req_bus.start_y <= r.start_y;
    req_bus.underlined <= r.underlined;
    req_bus.font_addr <= r.font_addr;
    req_bus.font_byte <= r.font_byte;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    raster.note_request(r);
    requests_sent++;
    if (r.req_type == REQ_WRITE) font_writes_sent++;
  endtask

  task automatic send_font_write(int unsigned addr, logic [BYTE_W-1:0] data);
    glyph_req_t r;
    r = glyph_req_t'({$urandom, $urandom});
    r.req_type = REQ_WRITE;
    r.font_addr = addr[ADDR_W-1:0];
    r.font_byte = data;
    font_written[addr % FONT_BYTES] = 1'b1;
    send_request(r);
  endtask

  // Draw one character; load any font byte the glyph could touch first
  task automatic send_char(logic [CHAR_W-1:0] code, bit first, int sx, int sy, bit ul);
    glyph_req_t r;
    int unsigned lo, hi, b;
    if (code != CODE_NEWLINE && code != CODE_DOT) begin
      raster.glyph_span(code, lo, hi);
      for (b = lo; b <= hi + 1; b++)
        if (!font_written[b % FONT_BYTES])
          send_font_write(b % FONT_BYTES, $urandom_range(0, 255));
    end
    r.req_type = REQ_DRAW;
    r.char_code = code;
    r.first_of_string = first;
    r.start_x = sx[START_W-1:0];
    r.start_y = sy[START_W-1:0];
    r.underlined = ul;
    r.font_addr = $urandom_range(0, FONT_BYTES - 1);
    r.font_byte = $urandom_range(0, 255);
    send_request(r);
  endtask

  // Start coordinate near a clip edge, inside the window, or anywhere
  function automatic int pick_coord(int lo, int hi);
    int v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)
      v = lo - 20 + int'($urandom_range(0, 40));
    else if (r < 60)
      v = hi - 20 + int'($urandom_range(0, 40));
    else if (r < 85)
      v = (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
    else
      v = int'($urandom_range(0, 8191)) - 4096;
    if (v < -4096) v = -4096;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Mostly whole strings with random content, some stray writes and draws
  task automatic run_strings(int budget, int pal_n);
    logic [CHAR_W-1:0] palette [8];
    logic [CHAR_W-1:0] code;
    int unsigned r;
    int base_count, len, k, sx, sy;
    foreach (palette[i]) palette[i] = $urandom_range(0, 255);
    base_count = requests_sent;
    while (requests_sent - base_count < budget) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1))
          send_font_write($urandom_range(0, FONT_BYTES - 1), $urandom_range(0, 255));
        else
          send_char(palette[0], $urandom_range(0, 1), int'($urandom_range(0, 8191)) - 4096,
                    int'($urandom_range(0, 8191)) - 4096, $urandom_range(0, 1));
      end else begin
        sx = pick_coord(raster.clip_l, raster.clip_r);
        sy = pick_coord(raster.clip_t, raster.clip_b);
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 10)
            code = CODE_NEWLINE;
          else if (r < 18)
            code = CODE_DOT;
          else if (r < 90)
            code = palette[$urandom_range(0, pal_n - 1)];
          else
            code = $urandom_range(0, 255);
          send_char(code, k == 0, sx, sy, $urandom_range(0, 1));
        end
      end
    end
  endtask

  // Drop valid, collect every owed run, then let trailing work finish
  task automatic wait_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (raster.pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_DRAW;
    req_bus.char_code = '0;
    req_bus.first_of_string = 1'b0;
    req_bus.start_x = '0;
    req_bus.start_y = '0;
    req_bus.underlined = 1'b0;
    req_bus.font_addr = '0;
    req_bus.font_byte = '0;
    run_bus.ready = 1'b0;
    requests_sent = 0;
    font_writes_sent = 0;
    settings_run = 0;
    set_pacing(PACE_SRC_LIGHT);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: short cells so each glyph needs few font bytes
    cfg_write(CFG_GLYPH_H, 2);
    cfg_write(CFG_STRIDE, 16);
    settings_run++;
    send_font_write(FONT_BYTES - 1, 8'hFF);
    send_font_write(0, 8'h00);
    send_char(8'h00, 1, 0, 0, 1);
    send_char(8'hFF, 0, 0, 0, 0);
    send_char(CODE_DOT, 0, 0, 0, 0);
    send_char(CODE_NEWLINE, 0, 0, 0, 0);
    send_char(8'h41, 0, 0, 0, 1);
    // Rejected far left and top, then the far corner with rows clipped
    send_char(8'h41, 1, -4096, -4096, 1);
    send_char(8'h42, 1, 4095, 4095, 1);
    // Partly clipped on the left, on the top and on the right
    send_char(8'h43, 1, -4, -1, 1);
    send_char(CODE_DOT, 1, -5, -1, 0);
    send_char(CODE_DOT, 1, -4, -1, 0);
    send_char(8'h7E, 1, 4088, 100, 1);

    run_strings(40, 5);

    // Largest cells with a 256-bit stride, small window
    wait_idle();
    random_clip();
    set_glyph(16, 16, 256);
    settings_run++;
    run_strings(50, 2);

    // Single-pixel cells, full window
    wait_idle();
    set_pacing(PACE_SRC_HEAVY);
    set_clip(0, 0, 4095, 4095);
    set_glyph(1, 1, 1);
    settings_run++;
    run_strings(50, 6);

    // Out-of-range sizes saturate, zero stride shares one glyph
    wait_idle();
    random_clip();
    set_glyph(0, 31, 0);
    settings_run++;
    run_strings(50, 4);

    // Random cell with packed stride
    wait_idle();
    set_pacing(PACE_NONE);
    random_clip();
    w = $urandom_range(1, 16);
    h = $urandom_range(1, 16);
    set_glyph(w, h, w * h);
    settings_run++;
    run_strings(50, 4);

    // Inverted window at the far edges, widest stride wraps the font address
    wait_idle();
    set_clip(4095, 4095, 0, 0);
    set_glyph(31, $urandom_range(1, 16), 511);
    settings_run++;
    run_strings(20, 2);

    // Random cell and stride
    wait_idle();
    random_clip();
    set_glyph($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 511));
    settings_run++;
    run_strings(50, 4);

    wait_idle();
    $display("covered %0d requests (%0d font writes) over %0d register settings",
             requests_sent, font_writes_sent, settings_run);
    $display("checked %0d pixel runs, %0d mismatches", raster.runs_checked,
             raster.mismatches);
    if (raster.mismatches == 0 && raster.pending_runs.size() == 0) begin
      $display("[clipped_bitmap_text_renderer] OK");
    end else begin
      $display("[clipped_bitmap_text_renderer] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cbtr_pkg.sv
rtl/cbtr_req_if.sv
rtl/cbtr_run_if.sv
rtl/cbtr_font_mem.sv
rtl/cbtr_row_packer.sv
rtl/clipped_bitmap_text_renderer.sv
dv/tb.sv
